@@ rtl/repeating_multi_timer_scheduler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the repeating multi-timer scheduler
// Concurrent assertion wrappers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef REPEATING_MULTI_TIMER_SCHEDULER_ASSERT_SVH
`define REPEATING_MULTI_TIMER_SCHEDULER_ASSERT_SVH

// Check on every rising edge, reset included.
`define RMTS_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Check on every rising edge outside reset.
`define RMTS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/rmts_pkg.sv @@
// ----------------------------------------------------------------------------
// rmts_pkg
// Constants, codes and types of the repeating multi-timer scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rmts_pkg;

   localparam int NUM_TIMERS   = 4;
   localparam int MAX_ELAPSED  = 15;
   localparam int PERIOD_BITS  = 16;
   localparam int ELAPSED_BITS = 4;
   localparam int REPEAT_BITS  = 16;
   localparam int ACTION_BITS  = 2;
   localparam int KIND_BITS    = 2;
   localparam int SLOT_BITS    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   // countdown holds -MAX_ELAPSED .. 2^PERIOD_BITS-1
   localparam int CD_BITS      = PERIOD_BITS + 2;

   localparam int REQ_FIELD_BITS = ELAPSED_BITS + PERIOD_BITS + REPEAT_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = SLOT_BITS + REPEAT_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [ACTION_BITS-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_ADD   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_START = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_FIRE   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      logic [CD_BITS-1:0] sum;
      logic               le_zero;
   } alu_res_type;

endpackage

`default_nettype wire

@@ rtl/rmts_cd_alu.sv @@
// ----------------------------------------------------------------------------
// rmts_cd_alu
// Shared countdown adder: subtracts elapsed ticks or adds back a period,
// and flags a result at or below zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rmts_cd_alu (
   input  wire logic [rmts_pkg::CD_BITS-1:0]      cd_value,
   input  wire logic                              use_sub,
   input  wire logic [rmts_pkg::ELAPSED_BITS-1:0] elapsed,
   input  wire logic [rmts_pkg::PERIOD_BITS-1:0]  period,
   output rmts_pkg::alu_res_type                  result
);

   logic [rmts_pkg::CD_BITS-1:0] operand;
   logic [rmts_pkg::CD_BITS-1:0] sum;

   // one adder: subtract as add of the complement plus carry in
   assign operand = use_sub
      ? ~{{(rmts_pkg::CD_BITS - rmts_pkg::ELAPSED_BITS){1'b0}}, elapsed}
      :  {{(rmts_pkg::CD_BITS - rmts_pkg::PERIOD_BITS){1'b0}}, period};

   assign sum = cd_value + operand + {{(rmts_pkg::CD_BITS - 1){1'b0}}, use_sub};

   assign result.sum     = sum;
   assign result.le_zero = sum[rmts_pkg::CD_BITS-1] || (sum == '0);

endmodule

`default_nettype wire

@@ rtl/repeating_multi_timer_scheduler.sv @@
// Tick: the request is taken, then each slot in turn has its countdown advanced; in emit
//   mode each firing but the one that frees the slot is followed by adding back the period,
//   in skip mode a due slot fires once and then adds back periods, and a flush step closes;
//   the walk ends at the slot that empties the table, and a full response path stalls it.
// Add uses S_FLUSH, start and ignored ones don't. Ready only while the sequencer is idle.
// Reset (synchronous, active high) clears the table, stops the timers, sets missed_mode to 0.
// ----------------------------------------------------------------------------
// repeating_multi_timer_scheduler
// Table of periodic timers with repeat counts, walked slot by slot per tick.
// ----------------------------------------------------------------------------
`default_nettype none

`include "repeating_multi_timer_scheduler_assert.svh"

module repeating_multi_timer_scheduler (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // config register missed_mode
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic                                csr_data,
   // request channel
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // [3:0] elapsed_ticks, [19:4] timer_period, [35:20] repeat_count, rest zero
   input  wire logic [rmts_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [1:0] action
   input  wire logic [rmts_pkg::ACTION_BITS-1:0]    req_tuser,
   // response channel
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [1:0] timer_slot, [17:2] repeats_left, [18] all_done, rest zero
   output      logic [rmts_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // [1:0] kind
   output      logic [rmts_pkg::KIND_BITS-1:0]      rsp_tuser,
   output      logic                                rsp_tlast
);

   localparam int NT = rmts_pkg::NUM_TIMERS;
   localparam int SB = rmts_pkg::SLOT_BITS;
   localparam int PB = rmts_pkg::PERIOD_BITS;
   localparam int RB = rmts_pkg::REPEAT_BITS;
   localparam int EB = rmts_pkg::ELAPSED_BITS;
   localparam int CB = rmts_pkg::CD_BITS;
   localparam int KB = rmts_pkg::KIND_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SUB   = 3'd1;
   localparam logic [2:0] S_FIRE  = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic [EB-1:0] elapsed_ff, elapsed_in;
   logic          mode_ff, mode_in;
   logic          running_ff, running_in;
   logic [NT-1:0] valid_ff, valid_in;

   // timer table
   logic [PB-1:0] period_ff [NT];
   logic [PB-1:0] period_in [NT];
   logic [RB-1:0] reps_ff [NT];
   logic [RB-1:0] reps_in [NT];
   logic [CB-1:0] cd_ff [NT];
   logic [CB-1:0] cd_in [NT];

   // pending response, held until it is known whether it is the last one
   logic          pend_valid_ff, pend_valid_in;
   logic [KB-1:0] pend_kind_ff, pend_kind_in;
   logic [SB-1:0] pend_slot_ff, pend_slot_in;
   logic [RB-1:0] pend_left_ff, pend_left_in;
   logic          pend_done_ff, pend_done_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [KB-1:0] rsp_kind_ff, rsp_kind_in;
   logic [SB-1:0] rsp_slot_ff, rsp_slot_in;
   logic [RB-1:0] rsp_left_ff, rsp_left_in;
   logic          rsp_done_ff, rsp_done_in;
   logic          rsp_last_ff, rsp_last_in;

   // request fields
   logic [EB-1:0] req_elapsed;
   logic [PB-1:0] req_period;
   logic [RB-1:0] req_repeats;

   rmts_pkg::alu_res_type alu_res;

   logic          req_fire;
   logic          out_free;
   logic          emit_ok;
   logic          last_slot;
   logic          free_found;
   logic [SB-1:0] free_slot;
   logic [RB-1:0] reps_dec;
   logic [NT-1:0] valid_left;
   logic          table_done;

   assign req_elapsed = req_tdata[EB-1:0];
   assign req_period  = req_tdata[EB+PB-1:EB];
   assign req_repeats = req_tdata[EB+PB+RB-1:EB+PB];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_ok    = !pend_valid_ff || out_free;
   assign last_slot  = (slot_ff == SB'(NT - 1));
   assign reps_dec   = reps_ff[slot_ff] - RB'(1);

   rmts_cd_alu u_alu (
      .cd_value (cd_ff[slot_ff]),
      .use_sub  (state_ff == S_SUB),
      .elapsed  (elapsed_ff),
      .period   (period_ff[slot_ff]),
      .result   (alu_res)
   );

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NT - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SB'(i);
         end
      end
   end

   // slots still loaded once the current slot is freed
   always_comb begin
      valid_left          = valid_ff;
      valid_left[slot_ff] = 1'b0;
      table_done          = (valid_left == '0);
   end

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      elapsed_in    = elapsed_ff;
      mode_in       = mode_ff;
      running_in    = running_ff;
      valid_in      = valid_ff;
      period_in     = period_ff;
      reps_in       = reps_ff;
      cd_in         = cd_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      pend_left_in  = pend_left_ff;
      pend_done_in  = pend_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  rmts_pkg::ACT_ADD: begin
                     if (req_repeats != '0) begin
                        pend_valid_in = 1'b1;
                        pend_done_in  = 1'b0;
                        state_in      = S_FLUSH;
                        if (!running_ff && free_found) begin
                           valid_in[free_slot]  = 1'b1;
                           period_in[free_slot] = (req_period == '0) ? PB'(1) : req_period;
                           reps_in[free_slot]   = req_repeats;
                           pend_kind_in         = rmts_pkg::KIND_ACCEPT;
                           pend_slot_in         = free_slot;
                           pend_left_in         = req_repeats;
                        end else begin
                           pend_kind_in = rmts_pkg::KIND_REJECT;
                           pend_slot_in = '0;
                           pend_left_in = '0;
                        end
                     end
                  end
                  rmts_pkg::ACT_START: begin
                     if (!running_ff && (valid_ff != '0)) begin
                        running_in = 1'b1;
                        for (int i = 0; i < NT; i++) begin
                           if (valid_ff[i]) begin
                              cd_in[i] = {{(CB - PB){1'b0}}, period_ff[i]};
                           end
                        end
                     end
                  end
                  rmts_pkg::ACT_TICK: begin
                     if (running_ff) begin
                        elapsed_in = (req_elapsed > EB'(rmts_pkg::MAX_ELAPSED))
                                   ? EB'(rmts_pkg::MAX_ELAPSED) : req_elapsed;
                        slot_in    = '0;
                        state_in   = S_SUB;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SUB: begin
            if (valid_ff[slot_ff]) begin
               cd_in[slot_ff] = alu_res.sum;
            end
            if (valid_ff[slot_ff] && alu_res.le_zero) begin
               state_in = S_FIRE;
            end else if (last_slot) begin
               state_in = S_FLUSH;
            end else begin
               slot_in = slot_ff + SB'(1);
            end
         end

         S_FIRE: begin
            // stall while both the pending and the output register are full
            if (emit_ok) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pend_kind_ff;
                  rsp_slot_in  = pend_slot_ff;
                  rsp_left_in  = pend_left_ff;
                  rsp_done_in  = pend_done_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in    = 1'b1;
               pend_kind_in     = rmts_pkg::KIND_FIRE;
               pend_slot_in     = slot_ff;
               reps_in[slot_ff] = reps_dec;
               if (reps_dec == '0) begin
                  valid_in[slot_ff] = 1'b0;
                  pend_left_in      = '0;
                  pend_done_in      = table_done;
                  if (table_done) begin
                     running_in = 1'b0;
                  end
                  if (table_done || last_slot) begin
                     state_in = S_FLUSH;
                  end else begin
                     slot_in  = slot_ff + SB'(1);
                     state_in = S_SUB;
                  end
               end else begin
                  pend_left_in = reps_dec;
                  pend_done_in = 1'b0;
                  state_in     = S_ADD;
               end
            end
         end

         S_ADD: begin
            cd_in[slot_ff] = alu_res.sum;
            if (alu_res.le_zero) begin
               // skip mode keeps adding periods without firing
               if (!mode_ff) begin
                  state_in = S_FIRE;
               end
            end else if (last_slot) begin
               state_in = S_FLUSH;
            end else begin
               slot_in  = slot_ff + SB'(1);
               state_in = S_SUB;
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_left_in   = pend_left_ff;
               rsp_done_in   = pend_done_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= 1'b0;
         running_ff    <= 1'b0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         running_ff    <= running_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      elapsed_ff   <= elapsed_in;
      period_ff    <= period_in;
      reps_ff      <= reps_in;
      cd_ff        <= cd_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      pend_left_ff <= pend_left_in;
      pend_done_ff <= pend_done_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(rmts_pkg::RSP_DATA_BITS - rmts_pkg::RSP_FIELD_BITS){1'b0}},
                        rsp_done_ff, rsp_left_ff, rsp_slot_ff};

   `RMTS_ASSERT(a_reset_clears, clock,
      $past(reset) && !reset |-> !rsp_valid_ff && !running_ff,
      "reset left the block active")
   `RMTS_ASSERT_RST(a_idle_no_pending, clock, reset,
      state_ff == S_IDLE |-> !pend_valid_ff,
      "pending response left behind at idle")
   `RMTS_ASSERT_RST(a_running_loaded, clock, reset,
      running_ff |-> valid_ff != '0,
      "timers running with an empty table")
   `RMTS_ASSERT_RST(a_done_is_last, clock, reset,
      rsp_valid_ff && rsp_done_ff |-> rsp_last_ff && (rsp_kind_ff == rmts_pkg::KIND_FIRE),
      "all_done on a response that is not the final firing")
   `RMTS_ASSERT_RST(a_add_single, clock, reset,
      rsp_valid_ff && (rsp_kind_ff != rmts_pkg::KIND_FIRE) |-> rsp_last_ff,
      "add response not marked last")

endmodule

`default_nettype wire
